// ===== rtl/overwriting_ring_history_buffer_assert.svh =====
// assertion macros for the overwriting ring history buffer
// used by the top level only, no other dependencies
`ifndef OVERWRITING_RING_HISTORY_BUFFER_ASSERT_SVH
`define OVERWRITING_RING_HISTORY_BUFFER_ASSERT_SVH

// condition must never hold outside reset
`define ORHB_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("orhb assertion failed: forbidden condition seen");

// antecedent must be accompanied by consequent in the same cycle
`define ORHB_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orhb assertion failed: implication violated");

`endif

// ===== rtl/orhb_pkg.sv =====
// shared types and constants of the overwriting ring history buffer
// no dependencies
package orhb_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_BITS   = 32;
    localparam int PTR_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // input op codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] stored_value;
        logic        is_last;
    } out_item_t;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_DUMP = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [DATA_BITS-1:0]   value;
    } cmd_t;

    typedef struct packed {
        logic                   dumping;
        logic [PTR_BITS-1:0]    write_pointer;
        logic [CNT_BITS-1:0]    fill_count;
    } back_status_t;

endpackage

// ===== rtl/orhb_front.sv =====
// front stage: accepts items and turns them into ring commands
// depends on orhb_pkg
module orhb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  orhb_pkg::in_item_t item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output orhb_pkg::cmd_t    cmd
);
    import orhb_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    logic take;

    // stage is free when empty or when its command moves on
    assign item_ready = !cmd_valid_reg || cmd_ready;
    assign take       = item_valid && item_ready;
    assign cmd_valid  = cmd_valid_reg;
    assign cmd        = cmd_reg;

    // stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    // classify and trim the value to the stored width
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.kind  <= (item.op == OP_DUMP) ? CMD_DUMP : CMD_ADD;
            cmd_reg.value <= DATA_BITS'(item.new_value);
        end
    end

endmodule

// ===== rtl/orhb_queue.sv =====
// short command queue between front and back
// depends on orhb_pkg
module orhb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  orhb_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output orhb_pkg::cmd_t pop_cmd
);
    import orhb_pkg::*;

    cmd_t                 slots [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slots[rd_ptr_reg];

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/orhb_back.sv =====
// back end: holds the ring, applies adds and walks dumps into the result register
// depends on orhb_pkg
module orhb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  orhb_pkg::cmd_t         cmd,
    output logic                   result_valid,
    input  logic                   result_ready,
    output orhb_pkg::out_item_t    result,
    output orhb_pkg::back_status_t status
);
    import orhb_pkg::*;

    logic [DATA_BITS-1:0] entry_store [DEPTH];
    logic [PTR_BITS-1:0]  wp_reg;
    logic [CNT_BITS-1:0]  fill_reg;
    logic                 dumping_reg;
    logic [PTR_BITS-1:0]  rd_slot_reg;
    logic [CNT_BITS-1:0]  remain_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 pop;
    logic                 load;
    logic                 out_free;
    logic [PTR_BITS-1:0]  wp_inc;
    logic [PTR_BITS-1:0]  rd_inc;
    logic [CNT_BITS-1:0]  wp_wide;
    logic [PTR_BITS-1:0]  start_slot;

    assign cmd_ready    = !dumping_reg;
    assign pop          = cmd_valid && cmd_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign load         = dumping_reg && out_free;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign status.dumping       = dumping_reg;
    assign status.write_pointer = wp_reg;
    assign status.fill_count    = fill_reg;

    // pointer wrap
    assign wp_inc = (wp_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_inc = (rd_slot_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_slot_reg + 1'b1;

    // oldest entry sits fill_count slots behind the write pointer
    assign wp_wide = CNT_BITS'(wp_reg);
    always_comb
    begin
        if (wp_wide >= fill_reg)
        begin
            start_slot = PTR_BITS'(wp_wide - fill_reg);
        end
        else
        begin
            start_slot = PTR_BITS'(wp_wide + CNT_BITS'(DEPTH) - fill_reg);
        end
    end

    // ring control and dump walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            dumping_reg   <= 1'b0;
            rd_slot_reg   <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (cmd.kind == CMD_ADD)
                begin
                    wp_reg <= wp_inc;
                    if (fill_reg != CNT_BITS'(DEPTH))
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                else if (fill_reg != '0)
                begin
                    dumping_reg <= 1'b1;
                    rd_slot_reg <= start_slot;
                    remain_reg  <= fill_reg;
                end
            end

            if (load)
            begin
                rd_slot_reg <= rd_inc;
                remain_reg  <= remain_reg - 1'b1;
                if (remain_reg == CNT_BITS'(1))
                begin
                    dumping_reg <= 1'b0;
                end
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ring storage
    always_ff @(posedge clk)
    begin
        if (pop && (cmd.kind == CMD_ADD))
        begin
            entry_store[wp_reg] <= cmd.value;
        end
    end

    // result register, read straight out of the ring
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.stored_value <= 32'(entry_store[rd_slot_reg]);
            out_reg.is_last      <= (remain_reg == CNT_BITS'(1));
        end
    end

endmodule

// ===== rtl/overwriting_ring_history_buffer.sv =====
// overwriting ring history buffer, top level
// path: an add passes the front register and the command queue before it is written to the ring;
// a dump is walked oldest first into the result register, one entry per cycle while result_ready is high
// throughput: one add per cycle while the queue has room; a dump holds the back end until its last entry is loaded
// reset: pointers, fill count and handshakes clear at once; the ring contents are
// left undefined and are never shown before being written, so no clearing pass
module overwriting_ring_history_buffer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  orhb_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output orhb_pkg::out_item_t result
);
    import orhb_pkg::*;

    `include "overwriting_ring_history_buffer_assert.svh"

    logic         fr_valid;
    logic         fr_ready;
    cmd_t         fr_cmd;
    logic         bk_valid;
    logic         bk_ready;
    cmd_t         bk_cmd;
    back_status_t status;

    // accept and classify
    orhb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (fr_valid),
        .cmd_ready  (fr_ready),
        .cmd        (fr_cmd)
    );

    // decoupling queue
    orhb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_cmd    (bk_cmd)
    );

    // ring and dump walk
    orhb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (bk_valid),
        .cmd_ready    (bk_ready),
        .cmd          (bk_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .status       (status)
    );

    // fill count saturates at the ring depth
    `ORHB_ASSERT_NEVER(fill_in_range, clk, rst_n, status.fill_count > CNT_BITS'(DEPTH))
    // until full, the write pointer tracks the fill count
    `ORHB_ASSERT_IMPLIES(wp_tracks_fill, clk, rst_n, status.fill_count != CNT_BITS'(DEPTH), CNT_BITS'(status.write_pointer) == status.fill_count)
    // no command is taken while a dump is being walked
    `ORHB_ASSERT_NEVER(no_pop_in_dump, clk, rst_n, status.dumping && bk_ready)

endmodule
